### rtl/ksrs_pkg.sv
// ----------------------------------------------------------------------------
// ksrs_pkg
// Shared types, register indexes and sizes for the KS/RS row generator.
// ----------------------------------------------------------------------------
package ksrs_pkg;

  localparam int unsigned FieldW   = 10;
  localparam int unsigned CodeW    = 7;
  localparam int unsigned MsgW     = 5;
  localparam int unsigned GroupW   = 17;
  localparam int unsigned ColW     = 16;
  localparam int unsigned RowW     = 16;
  localparam int unsigned PointW   = 6;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgAddrW-1:0] RegFieldSize     = 2'd0;
  localparam logic [CfgAddrW-1:0] RegCodeLength    = 2'd1;
  localparam logic [CfgAddrW-1:0] RegMessageLength = 2'd2;
  localparam logic [CfgAddrW-1:0] RegGroupSize     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_EVAL,
    ST_EMIT,
    ST_ERR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture column, start digit split
    logic digit_step;  // one restoring-division step
    logic eval_start;  // start Horner for current point
    logic eval_step;   // one Horner step: a coefficient start or a multiply bit
    logic emit;        // capture a result into the output register
    logic next_point;  // advance evaluation point
    logic err_emit;    // capture the error result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic digits_done;
    logic eval_done;
    logic last_point;
  } status_t;

endpackage

### rtl/ksrs_datapath.sv
// ----------------------------------------------------------------------------
// ksrs_datapath
// Digit split by bit-serial restoring division, Horner evaluation with a
// serial shift-add modular multiplier, and result formation.
// ----------------------------------------------------------------------------
module ksrs_datapath
  import ksrs_pkg::*;
#(
  parameter int unsigned MAX_CODE_LENGTH = 64,
  parameter int unsigned MAX_DIGITS      = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output status_t             status_o,
  input  logic [ColW-1:0]     column_index_i,
  input  logic [FieldW-1:0]   field_size_i,
  input  logic [CodeW-1:0]    code_length_i,
  input  logic [MsgW-1:0]     message_length_i,
  input  logic [GroupW-1:0]   group_size_i,
  output logic [RowW-1:0]     row_index_o,
  output logic [PointW-1:0]   eval_point_o,
  output logic [FieldW-1:0]   symbol_o,
  output logic                last_o,
  output logic                error_o
);

  localparam int unsigned DigW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned PtW  = $clog2(MAX_CODE_LENGTH + 1);
  localparam int unsigned BitW = $clog2(ColW);
  localparam int unsigned MulW = $clog2(FieldW);

  // effective configuration
  logic [FieldW-1:0] q;
  logic [PtW-1:0]    n_eff;
  logic [DigW:0]     k_eff;
  always_comb begin
    q = (field_size_i < FieldW'(2)) ? FieldW'(2) : field_size_i;
    if (code_length_i == '0) n_eff = PtW'(1);
    else if (32'(code_length_i) > MAX_CODE_LENGTH) n_eff = PtW'(MAX_CODE_LENGTH);
    else n_eff = PtW'(code_length_i);
    if (message_length_i == '0) k_eff = (DigW+1)'(1);
    else if (32'(message_length_i) > MAX_DIGITS) k_eff = (DigW+1)'(MAX_DIGITS);
    else k_eff = (DigW+1)'(message_length_i);
  end

  assign status_o.in_range = {1'b0, column_index_i} < group_size_i;

  // ---- digit split: rest / q, one quotient bit per cycle ----
  logic [ColW-1:0]   rest_q, rest_d;
  logic [FieldW:0]   rem_q, rem_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic [DigW:0]     dcnt_q, dcnt_d;
  logic [FieldW-1:0] digit_q [MAX_DIGITS];
  logic [FieldW+1:0] trial;
  logic [FieldW:0]   rem_next;

  always_comb begin
    trial    = {rem_q, rest_q[bit_q]};
    rem_next = (trial >= {2'b00, q}) ? (FieldW+1)'(trial - {2'b00, q}) : trial[FieldW:0];
    rest_d = rest_q;
    rem_d  = rem_q;
    bit_d  = bit_q;
    dcnt_d = dcnt_q;
    if (ctrl_i.load) begin
      rest_d = column_index_i;
      rem_d  = '0;
      bit_d  = BitW'(ColW - 1);
      dcnt_d = '0;
    end else if (ctrl_i.digit_step) begin
      rem_d = rem_next;
      rest_d[bit_q] = (trial >= {2'b00, q});
      if (bit_q == '0) begin
        rem_d  = '0;
        bit_d  = BitW'(ColW - 1);
        dcnt_d = dcnt_q + 1'b1;
      end else begin
        bit_d = bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.digit_step && bit_q == '0) digit_q[dcnt_q[DigW-1:0]] <= rem_next[FieldW-1:0];
  end

  assign status_o.digits_done = (dcnt_q == k_eff);

  // ---- Horner: acc = acc*x + d mod q, multiply by serial shift-add ----
  logic [PtW-1:0]    pt_q, pt_d;
  logic [FieldW-1:0] x_q, x_d;
  logic [FieldW-1:0] acc_q, acc_d;
  logic [FieldW-1:0] prod_q, prod_d;
  logic [MulW-1:0]   mb_q, mb_d;
  logic [DigW:0]     j_q, j_d;
  logic              mul_q, mul_d;
  logic [FieldW:0]   dbl, sum, ad;
  logic [FieldW-1:0] dbl_m, sum_m, ad_m;

  always_comb begin
    dbl   = {prod_q, 1'b0};
    dbl_m = (dbl >= {1'b0, q}) ? FieldW'(dbl - {1'b0, q}) : dbl[FieldW-1:0];
    sum   = {1'b0, dbl_m} + {1'b0, acc_q};
    sum_m = x_q[mb_q] ? ((sum >= {1'b0, q}) ? FieldW'(sum - {1'b0, q}) : sum[FieldW-1:0])
                      : dbl_m;
    // product plus the current coefficient, used on the last multiply step
    ad    = {1'b0, sum_m} + {1'b0, digit_q[j_q[DigW-1:0]]};
    ad_m  = (ad >= {1'b0, q}) ? FieldW'(ad - {1'b0, q}) : ad[FieldW-1:0];
  end

  always_comb begin
    pt_d = pt_q; x_d = x_q; acc_d = acc_q; prod_d = prod_q;
    mb_d = mb_q; j_d = j_q; mul_d = mul_q;
    if (ctrl_i.load) begin
      pt_d = '0;
      x_d  = '0;
    end else if (ctrl_i.next_point) begin
      pt_d = pt_q + 1'b1;
      x_d  = (x_q + 1'b1 == q) ? '0 : x_q + 1'b1;
    end
    if (ctrl_i.eval_start) begin
      acc_d = '0; prod_d = '0; j_d = k_eff; mul_d = 1'b0;
      mb_d = MulW'(FieldW - 1);
    end else if (ctrl_i.eval_step) begin
      if (!mul_q) begin
        // new coefficient: acc currently holds previous value; multiply acc*x
        j_d = j_q - 1'b1;
        prod_d = '0;
        mb_d = MulW'(FieldW - 1);
        mul_d = 1'b1;
      end else if (mb_q != '0) begin
        prod_d = sum_m;
        mb_d = mb_q - 1'b1;
      end else begin
        prod_d = sum_m;
        mul_d  = 1'b0;
        acc_d  = ad_m;
      end
    end
  end

  assign status_o.eval_done  = !mul_q && (j_q == '0);
  assign status_o.last_point = (pt_q + 1'b1 == n_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      dcnt_q <= '0;
      mul_q  <= 1'b0;
      j_q    <= '0;
    end else begin
      bit_q  <= bit_d;
      dcnt_q <= dcnt_d;
      mul_q  <= mul_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d; rem_q <= rem_d;
    pt_q <= pt_d; x_q <= x_d; acc_q <= acc_d; prod_q <= prod_d; mb_q <= mb_d;
  end

  // result register
  logic [RowW+FieldW:0] row_full;
  assign row_full = (RowW+FieldW+1)'(pt_q) * (RowW+FieldW+1)'(q)
                  + (RowW+FieldW+1)'(acc_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      row_index_o  <= row_full[RowW-1:0];
      eval_point_o <= PointW'(pt_q);
      symbol_o     <= acc_q;
      last_o       <= status_o.last_point;
      error_o      <= 1'b0;
    end else if (ctrl_i.err_emit) begin
      row_index_o  <= '0;
      eval_point_o <= '0;
      symbol_o     <= '0;
      last_o       <= 1'b1;
      error_o      <= 1'b1;
    end
  end

endmodule

### rtl/ksrs_ctrl.sv
// ----------------------------------------------------------------------------
// ksrs_ctrl
// Sequencer: digit split, per-point evaluation and output handshake.
// ----------------------------------------------------------------------------
module ksrs_ctrl
  import ksrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    logic free;
    free    = !ov_q || out_ready_i;
    state_d = state_q;
    ctrl_o  = '0;
    ov_d    = ov_q && !out_ready_i;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = status_i.in_range ? ST_DIGIT : ST_ERR;
        end
      end
      ST_DIGIT: begin
        if (status_i.digits_done) begin
          ctrl_o.eval_start = 1'b1;
          state_d = ST_EVAL;
        end else begin
          ctrl_o.digit_step = 1'b1;
        end
      end
      ST_EVAL: begin
        if (status_i.eval_done) state_d = ST_EMIT;
        else ctrl_o.eval_step = 1'b1;
      end
      ST_EMIT: begin
        if (free) begin
          ctrl_o.emit = 1'b1;
          ov_d = 1'b1;
          if (status_i.last_point) begin
            state_d = ST_IDLE;
          end else begin
            ctrl_o.next_point = 1'b1;
            ctrl_o.eval_start = 1'b1;
            state_d = ST_EVAL;
          end
        end
      end
      ST_ERR: begin
        if (free) begin
          ctrl_o.err_emit = 1'b1;
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/ks_rs_column_row_generator.sv
// ----------------------------------------------------------------------------
// ks_rs_column_row_generator
// Sequence: accept, digit split (one quotient bit per cycle), a start step,
// then per point the Horner steps for each coefficient (a coefficient step and
// the multiply bit steps), a finish step and an emit; each result is valid the
// cycle after its emit. An out-of-range column is emitted from the error state
// once the result register is free. One column is handled at a time; a new
// column is accepted only when idle, and a full result register holds the emit.
// Reset: asynchronous active low; registers return to q=3, n=3, k=1, group=2.
// ----------------------------------------------------------------------------
module ks_rs_column_row_generator
  import ksrs_pkg::*;
#(
  parameter int unsigned MAX_CODE_LENGTH = 64,
  parameter int unsigned MAX_DIGITS      = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ColW-1:0]     column_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RowW-1:0]     row_index_o,
  output logic [PointW-1:0]   eval_point_o,
  output logic [FieldW-1:0]   symbol_o,
  output logic                last_o,
  output logic                error_o
);

  logic [FieldW-1:0] field_size_q;
  logic [CodeW-1:0]  code_length_q;
  logic [MsgW-1:0]   message_length_q;
  logic [GroupW-1:0] group_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_size_q     <= FieldW'(3);
      code_length_q    <= CodeW'(3);
      message_length_q <= MsgW'(1);
      group_size_q     <= GroupW'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegFieldSize:     field_size_q     <= cfg_data_i[FieldW-1:0];
        RegCodeLength:    code_length_q    <= cfg_data_i[CodeW-1:0];
        RegMessageLength: message_length_q <= cfg_data_i[MsgW-1:0];
        RegGroupSize:     group_size_q     <= cfg_data_i[GroupW-1:0];
        default: ;
      endcase
    end
  end

  ctrl_t   ctrl;
  status_t status;

  ksrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .ctrl_o(ctrl)
  );

  ksrs_datapath #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH), .MAX_DIGITS(MAX_DIGITS)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .status_o(status), .column_index_i,
    .field_size_i(field_size_q), .code_length_i(code_length_q),
    .message_length_i(message_length_q), .group_size_i(group_size_q),
    .row_index_o, .eval_point_o, .symbol_o, .last_o, .error_o
  );

endmodule
